// ----- hw/rtl/csg_pkg.sv -----
// Shared types, constants and SipHash helpers for the cuckoo edge generator.
// No dependencies; imported by every module of the block.
package csg_pkg;

    localparam int INDEX_W     = 32;
    localparam int NODE_W      = 30;
    localparam int KEY_W       = 64;
    localparam int GLOG_W      = 5;
    localparam int HALF_ROUNDS = 12;  // 2 compression + 4 finalisation rounds, halved
    localparam int HALF_COMP   = 4;   // half-rounds before message/0xff injection
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;
    localparam int REG_IDX_W   = 3;

    localparam logic [KEY_W-1:0]  FINAL_XOR    = 64'h0000_0000_0000_00ff;
    localparam logic [GLOG_W-1:0] GLOG_RESET   = 5'd20;

    localparam logic [REG_IDX_W-1:0] REG_KEY_0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLOG   = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] v0;
        logic [KEY_W-1:0] v1;
        logic [KEY_W-1:0] v2;
        logic [KEY_W-1:0] v3;
    } sip_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_0;
        logic [KEY_W-1:0]  key_1;
        logic [KEY_W-1:0]  key_2;
        logic [KEY_W-1:0]  key_3;
        logic [GLOG_W-1:0] graph_size_log2;
    } csg_cfg_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_odd;
        logic [NODE_W-1:0] node_even;
    } node_pair_t;

    function automatic logic [KEY_W-1:0] rotl64(input logic [KEY_W-1:0] x, input int r);
        return (x << r) | (x >> (KEY_W - r));
    endfunction

    // First half of a SipRound: one add level per lane pair
    function automatic sip_state_t sip_half_a(input sip_state_t s);
        sip_state_t t;
        t    = s;
        t.v0 = s.v0 + s.v1;
        t.v1 = rotl64(s.v1, 13) ^ t.v0;
        t.v0 = rotl64(t.v0, 32);
        t.v2 = s.v2 + s.v3;
        t.v3 = rotl64(s.v3, 16) ^ t.v2;
        return t;
    endfunction

    function automatic sip_state_t sip_half_b(input sip_state_t s);
        sip_state_t t;
        t    = s;
        t.v0 = s.v0 + s.v3;
        t.v3 = rotl64(s.v3, 21) ^ t.v0;
        t.v2 = s.v2 + s.v1;
        t.v1 = rotl64(s.v1, 17) ^ t.v2;
        t.v2 = rotl64(t.v2, 32);
        return t;
    endfunction

    // Fold the state, keep 30 bits and apply 2^(g-1)-1
    function automatic logic [NODE_W-1:0] fold_node(input sip_state_t s,
                                                    input logic [GLOG_W-1:0] g);
        logic [KEY_W-1:0] h;
        logic [31:0]      m;
        h = s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
        if (g == '0) begin
            m = '0;
        end else begin
            m = (32'd1 << (g - 5'd1)) - 32'd1;
        end
        return h[NODE_W-1:0] & m[NODE_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/csg_cfg_regs.sv -----
// APB register file holding the SipHash key words and graph size.
// Depends on csg_pkg.
module csg_cfg_regs
    import csg_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    output csg_cfg_t                cfg
);

    csg_cfg_t               cfg_reg;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_0           <= '0;
            cfg_reg.key_1           <= '0;
            cfg_reg.key_2           <= '0;
            cfg_reg.key_3           <= '0;
            cfg_reg.graph_size_log2 <= GLOG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_0: cfg_reg.key_0           <= pwdata;
                REG_KEY_1: cfg_reg.key_1           <= pwdata;
                REG_KEY_2: cfg_reg.key_2           <= pwdata;
                REG_KEY_3: cfg_reg.key_3           <= pwdata;
                REG_GLOG:  cfg_reg.graph_size_log2 <= pwdata[GLOG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_0: prdata = cfg_reg.key_0;
            REG_KEY_1: prdata = cfg_reg.key_1;
            REG_KEY_2: prdata = cfg_reg.key_2;
            REG_KEY_3: prdata = cfg_reg.key_3;
            REG_GLOG:  prdata = {{(DATA_W-GLOG_W){1'b0}}, cfg_reg.graph_size_log2};
            default:   prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/csg_sip_pipe.sv -----
// Twin SipHash-2-4 pipeline, one half-round per stage, even and odd lanes side by side.
// Depends on csg_pkg.
module csg_sip_pipe
    import csg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [INDEX_W-1:0]  in_index,
    input  csg_cfg_t            cfg,
    output logic                out_valid,
    output sip_state_t          out_even,
    output sip_state_t          out_odd
);

    sip_state_t             even_reg  [0:HALF_ROUNDS];
    sip_state_t             odd_reg   [0:HALF_ROUNDS];
    sip_state_t             even_in   [1:HALF_ROUNDS];
    sip_state_t             odd_in    [1:HALF_ROUNDS];
    logic [INDEX_W-1:0]     index_reg [0:HALF_COMP];
    logic [HALF_ROUNDS:0]   valid_reg;
    logic [INDEX_W-1:0]     msg_even_in;
    logic [INDEX_W-1:0]     msg_odd_in;
    logic [INDEX_W-1:0]     msg_even_mid;
    logic [INDEX_W-1:0]     msg_odd_mid;

    // message is 2*index+parity, wrapping at 32 bits
    assign msg_even_in  = {in_index[INDEX_W-2:0], 1'b0};
    assign msg_odd_in   = {in_index[INDEX_W-2:0], 1'b1};
    assign msg_even_mid = {index_reg[HALF_COMP][INDEX_W-2:0], 1'b0};
    assign msg_odd_mid  = {index_reg[HALF_COMP][INDEX_W-2:0], 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[HALF_ROUNDS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            even_reg[0] <= '{v0: cfg.key_0, v1: cfg.key_1, v2: cfg.key_2,
                             v3: cfg.key_3 ^ {{(KEY_W-INDEX_W){1'b0}}, msg_even_in}};
            odd_reg[0]  <= '{v0: cfg.key_0, v1: cfg.key_1, v2: cfg.key_2,
                             v3: cfg.key_3 ^ {{(KEY_W-INDEX_W){1'b0}}, msg_odd_in}};
            index_reg[0] <= in_index;
            for (int i = 1; i <= HALF_COMP; i++) begin
                index_reg[i] <= index_reg[i-1];
            end
        end
    end

    for (genvar k = 1; k <= HALF_ROUNDS; k++) begin : g_stage
        sip_state_t even_src;
        sip_state_t odd_src;

        always_comb begin
            even_src = even_reg[k-1];
            odd_src  = odd_reg[k-1];
            if (k == HALF_COMP + 1) begin
                // end of compression: message into v0, 0xff into v2
                even_src.v0 = even_src.v0 ^ {{(KEY_W-INDEX_W){1'b0}}, msg_even_mid};
                odd_src.v0  = odd_src.v0  ^ {{(KEY_W-INDEX_W){1'b0}}, msg_odd_mid};
                even_src.v2 = even_src.v2 ^ FINAL_XOR;
                odd_src.v2  = odd_src.v2  ^ FINAL_XOR;
            end
            if ((k % 2) == 1) begin
                even_in[k] = sip_half_a(even_src);
                odd_in[k]  = sip_half_a(odd_src);
            end else begin
                even_in[k] = sip_half_b(even_src);
                odd_in[k]  = sip_half_b(odd_src);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                even_reg[k] <= even_in[k];
                odd_reg[k]  <= odd_in[k];
            end
        end
    end

    assign out_valid = valid_reg[HALF_ROUNDS];
    assign out_even  = even_reg[HALF_ROUNDS];
    assign out_odd   = odd_reg[HALF_ROUNDS];

endmodule

// ----- hw/rtl/csg_out_skid.sv -----
// Output register plus skid slot: folds the final SipHash states into masked nodes.
// Depends on csg_pkg.
module csg_out_skid
    import csg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  sip_state_t          in_even,
    input  sip_state_t          in_odd,
    input  logic [GLOG_W-1:0]   graph_size_log2,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output node_pair_t          m_nodes
);

    node_pair_t out_reg;
    node_pair_t skid_reg;
    node_pair_t fold;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       out_free;

    assign fold.node_even = fold_node(in_even, graph_size_log2);
    assign fold.node_odd  = fold_node(in_odd, graph_size_log2);
    assign out_free       = !out_valid_reg || m_tready;
    assign in_ready       = !skid_valid_reg;
    assign m_tvalid       = out_valid_reg;
    assign m_nodes        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (out_free) begin
            out_valid_reg <= in_valid;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (out_free) begin
            out_reg <= fold;
        end else begin
            skid_reg <= fold;
        end
    end

endmodule

// ----- hw/rtl/cuckoo_siphash_edge_generator.sv -----
// Channel   | Beat payload                                  | Direction
// s_        | tdata[31:0] = edge_index                      | in
// m_        | tdata[29:0] = node_even, [59:30] = node_odd   | out
// APB       | 8-byte registers: key_0..key_3, graph_size_log2 | cfg
//
// One edge index per cycle while s_tready is high; each passes the input stage,
// 12 half-round stages and the output register. The adder chain of one half SipRound
// sets the stage depth. Reset is synchronous; in the datapath it clears valid bits
// only. A stalled m_ side fills the skid slot, then holds the whole pipe.
// Depends on csg_pkg, csg_cfg_regs, csg_sip_pipe, csg_out_skid.
module cuckoo_siphash_edge_generator
    import csg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,    // [31:0] edge_index
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,    // [29:0] node_even, [59:30] node_odd, pad
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    csg_cfg_t   cfg;
    logic       pipe_en;
    logic       pipe_valid;
    sip_state_t pipe_even;
    sip_state_t pipe_odd;
    node_pair_t nodes;

    csg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csg_sip_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_index  (s_tdata[INDEX_W-1:0]),
        .cfg       (cfg),
        .out_valid (pipe_valid),
        .out_even  (pipe_even),
        .out_odd   (pipe_odd)
    );

    csg_out_skid u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (pipe_valid),
        .in_even         (pipe_even),
        .in_odd          (pipe_odd),
        .graph_size_log2 (cfg.graph_size_log2),
        .in_ready        (pipe_en),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_nodes         (nodes)
    );

    assign s_tready = pipe_en;
    assign m_tdata  = {{(64-2*NODE_W){1'b0}}, nodes.node_odd, nodes.node_even};

endmodule
